### rtl/core/maf_pkg.sv
// ----------------------------------------------------------------------------
// maf_pkg
// Shared types for the moving average filter: back-end sequencer states and
// the divider status group.
// ----------------------------------------------------------------------------
package maf_pkg;

    localparam int AVG_W = 12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_START,
        ST_DIV,
        ST_OUT
    } t_back_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### rtl/core/maf_front.sv
// ----------------------------------------------------------------------------
// maf_front
// Input side: accepts sample beats into a two-entry queue that the back end
// drains at its own pace.
// ----------------------------------------------------------------------------
module maf_front #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_q_valid,
    output logic [SAMPLE_BITS-1:0] o_q_sample,
    input  logic                   i_q_pop
);

    logic [SAMPLE_BITS-1:0] r_mem [2];
    logic                   r_wr_ptr, n_wr_ptr;
    logic                   r_rd_ptr, n_rd_ptr;
    logic [1:0]             r_count, n_count;
    logic                   push;
    logic                   pop;

    assign o_stall    = (r_count == 2'd2);
    assign push       = i_valid && !o_stall;
    assign o_q_valid  = (r_count != 2'd0);
    assign pop        = i_q_pop && o_q_valid;
    assign o_q_sample = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_sample;
        end
    end

endmodule

### rtl/core/maf_div.sv
// ----------------------------------------------------------------------------
// maf_div
// Restoring divider, one quotient bit per cycle. Quotient holds after done
// until the next start.
// ----------------------------------------------------------------------------
module maf_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output maf_pkg::t_div_stat o_stat,
    output logic [NUM_W-1:0] o_quotient
);

    import maf_pkg::*;

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [NUM_W-1:0]  r_quo, n_quo;
    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [DEN_W-1:0]  r_den, n_den;
    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    rem_sub;

    assign rem_sh  = {r_rem, r_quo[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = STEP_W'(NUM_W);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_den  = i_divisor;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_den}) begin
                n_rem = rem_sub[DEN_W-1:0];
                n_quo = {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[DEN_W-1:0];
                n_quo = {r_quo[NUM_W-2:0], 1'b0};
            end
            n_step = r_step - STEP_W'(1);
            if (r_step == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

### rtl/core/maf_back.sv
// ----------------------------------------------------------------------------
// maf_back
// Execution side: sample ring, running sum, fill count and write pointer,
// sequenced through the divider into the output register.
// ----------------------------------------------------------------------------
module maf_back #(
    parameter int WINDOW      = 16,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  logic [SAMPLE_BITS-1:0]    i_q_sample,
    output logic                      o_q_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [maf_pkg::AVG_W-1:0] o_average
);

    import maf_pkg::*;

    localparam int AW    = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW);

    t_back_state r_state, n_state;

    logic [SAMPLE_BITS-1:0] r_mem [WINDOW];
    logic [SAMPLE_BITS-1:0] r_sample, n_sample;
    logic [SAMPLE_BITS-1:0] r_old;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [AW-1:0]          r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0]       r_count, n_count;
    logic                   r_full, n_full;
    logic                   r_out_valid, n_out_valid;
    logic [AVG_W-1:0]       r_average, n_average;

    logic                   mem_en;
    logic                   div_start;
    logic                   out_load;
    t_div_stat              div_stat;
    logic [SUM_W-1:0]       quotient;
    logic [SUM_W+AVG_W-1:0] quot_ext;
    logic [CNT_W-1:0]       count_inc;

    maf_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_stat     (div_stat),
        .o_quotient (quotient)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_q_valid) n_state = ST_READ;
            ST_READ:  n_state = ST_SUM;
            ST_SUM:   n_state = ST_START;
            ST_START: n_state = ST_DIV;
            ST_DIV:   if (div_stat.done) n_state = ST_OUT;
            ST_OUT:   if (!r_out_valid || !i_stall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_q_pop   = 1'b0;
        mem_en    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            ST_IDLE:  o_q_pop = i_q_valid;
            ST_READ:  mem_en = 1'b1;
            ST_START: div_start = 1'b1;
            ST_OUT:   out_load = !r_out_valid || !i_stall;
            default: begin
            end
        endcase
    end

    assign count_inc = r_count + CNT_W'(1);
    assign quot_ext  = {{AVG_W{1'b0}}, quotient};

    // Datapath
    always_comb begin
        n_sample    = r_sample;
        n_sum       = r_sum;
        n_wr_ptr    = r_wr_ptr;
        n_count     = r_count;
        n_full      = r_full;
        n_out_valid = r_out_valid;
        n_average   = r_average;
        if (o_q_pop) begin
            n_sample = i_q_sample;
        end
        if (r_state == ST_SUM) begin
            // the oldest sample leaves only once the ring has wrapped
            n_sum = r_sum - (r_full ? SUM_W'(r_old) : '0) + SUM_W'(r_sample);
            if (!r_full) begin
                n_count = count_inc;
                n_full  = (count_inc == CNT_W'(WINDOW));
            end
            n_wr_ptr = (r_wr_ptr == AW'(WINDOW - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        if (out_load) begin
            n_out_valid = 1'b1;
            n_average   = quot_ext[AVG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_wr_ptr    <= '0;
            r_count     <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_wr_ptr    <= n_wr_ptr;
            r_count     <= n_count;
            r_full      <= n_full;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample  <= n_sample;
        r_average <= n_average;
    end

    // read-before-write on the same slot returns the sample being replaced
    always_ff @(posedge i_clk) begin
        if (mem_en) begin
            r_old             <= r_mem[r_wr_ptr];
            r_mem[r_wr_ptr]   <= r_sample;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_average = r_average;

endmodule

### rtl/core/moving_average_filter.sv
// ----------------------------------------------------------------------------
// moving_average_filter
// Boxcar moving average over unsigned converter samples.
// ----------------------------------------------------------------------------
// Input beat: i_valid/o_stall handshake carrying i_sample. Output beat:
// o_valid/i_stall carrying o_average, one result per sample, in order.
// Each result is the truncated mean of the last WINDOW samples; before the
// window has filled, it is the mean of all samples seen since reset.
// Samples enter a two-entry queue; o_stall rises only when that queue is full.
// The back end handles one sample at a time, stepping through read, sum,
// divider start, divide and output. The bit-serial divider works on the
// running sum of SUM_W = SAMPLE_BITS + clog2(WINDOW) bits and produces one
// quotient bit per cycle.
// Reset (synchronous, active low) empties the queue and the output register
// and clears the sum, fill count and pointer; the sample ring needs no clear.
// While the receiver stalls, o_average holds, the back end finishes its
// current sample and waits, and the queue keeps taking up to two more beats.
// ----------------------------------------------------------------------------
module moving_average_filter #(
    parameter int WINDOW      = 16,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [SAMPLE_BITS-1:0]    i_sample,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [maf_pkg::AVG_W-1:0] o_average
);

    logic                   q_valid;
    logic [SAMPLE_BITS-1:0] q_sample;
    logic                   q_pop;

    maf_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_sample   (i_sample),
        .o_q_valid  (q_valid),
        .o_q_sample (q_sample),
        .i_q_pop    (q_pop)
    );

    maf_back #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_sample (q_sample),
        .o_q_pop    (q_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_average  (o_average)
    );

endmodule

### rtl/core/maf_checker.sv
// ----------------------------------------------------------------------------
// maf_checker
// Port-level checks for the moving average filter: output beat stability
// and bounds on the number of samples held inside.
// ----------------------------------------------------------------------------
module maf_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [maf_pkg::AVG_W-1:0] o_average
);

    logic       in_beat;
    logic       out_beat;
    logic [2:0] r_held, n_held;

    assign in_beat  = i_valid && !o_stall;
    assign out_beat = o_valid && !i_stall;

    always_comb begin
        n_held = r_held;
        if (in_beat && !out_beat) begin
            n_held = r_held + 3'd1;
        end else if (out_beat && !in_beat) begin
            n_held = r_held - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 3'd0;
        end else begin
            r_held <= n_held;
        end
    end

    // a stalled result stays put
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_average))
        else $error("output beat changed while stalled");

    // results leave only through a completed beat
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(o_valid) |-> $past(!i_stall))
        else $error("output valid dropped without a beat");

    // no result without a sample behind it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat |-> r_held != 3'd0)
        else $error("result with no sample outstanding");

    // queue, back end and output register hold at most four samples
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= 3'd4)
        else $error("too many samples held");

    // input stall only when at least two samples are held inside
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_held >= 3'd2)
        else $error("input stalled with queue not full");

endmodule

bind moving_average_filter maf_checker u_maf_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_average (o_average)
);

### tb/tb_moving_average_filter.sv
// ----------------------------------------------------------------------------
// tb_moving_average_filter
// Self-checking bench for the boxcar moving average filter.
// ----------------------------------------------------------------------------
// A short table of samples covers warm-up from reset, a window full of
// maximum samples, pointer wrap and single-bit patterns. Random segments
// follow, biased now and then toward high or low values so that the running
// sum sits near its limits. Every accepted sample runs through a local copy
// of the filter, and each average the block returns is compared in order.
// Both sides idle in random bursts; once the receiver holds off long enough
// for the input queue to fill and push back.
// ----------------------------------------------------------------------------
module tb_moving_average_filter;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW      = 16;
    localparam int SAMPLE_BITS = 12;
    localparam int AVG_W       = maf_pkg::AVG_W;

    localparam int N_ROWS      = 22;
    localparam int N_RANDOM    = 780;
    localparam int QUIET_ITEMS = 100;   // tail of the run with no idling
    localparam int HOLD_AT     = 300;   // samples sent before the long hold-off
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 40;
    localparam int STUCK_LIMIT = 4000;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   typed;
        logic [AVG_W-1:0]       average;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic [SAMPLE_BITS-1:0] i_sample;
    logic                   o_valid;
    logic                   i_stall;
    logic [AVG_W-1:0]       o_average;

    // typed expectation travelling with the current input beat
    logic                   row_typed;
    logic [AVG_W-1:0]       row_average;

    // local filter state
    logic [SAMPLE_BITS-1:0] win_ring [WINDOW];
    logic [15:0]            win_sum;
    logic [3:0]             win_ptr;
    logic [4:0]             win_fill;
    logic                   win_full;

    logic [AVG_W-1:0]       averages_due [$];
    logic [AVG_W-1:0]       predicted;
    t_row                   rows [N_ROWS];

    int  errors       = 0;
    int  samples_sent = 0;
    int  samples_in   = 0;
    int  averages_out = 0;
    int  pushback     = 0;
    int  stuck        = 0;
    bit  quiet        = 0;
    bit  hold_done    = 0;

    moving_average_filter #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_sample  (i_sample),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_average (o_average)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // advances the local filter by one sample and returns the new mean
    function automatic logic [AVG_W-1:0] next_average(input logic [SAMPLE_BITS-1:0] s);
        logic [15:0] divisor;
        if (win_full) begin
            win_sum = win_sum - 16'(win_ring[win_ptr]);
        end else begin
            win_fill = win_fill + 5'd1;
            if (win_fill == 5'(WINDOW)) win_full = 1'b1;
        end
        win_ring[win_ptr] = s;
        win_sum = win_sum + 16'(s);
        win_ptr = win_ptr + 4'd1;
        divisor = win_full ? 16'(WINDOW) : 16'(win_fill);
        return AVG_W'(win_sum / divisor);
    endfunction

    task automatic report_mismatch(input string what, input logic [AVG_W-1:0] got,
                                   input logic [AVG_W-1:0] want);
        $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
        errors++;
    endtask

    // scoreboard: predict on each input beat, check each output beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predicted = next_average(i_sample);
                averages_due.push_back(row_typed ? row_average : predicted);
                samples_in++;
            end
            if (i_valid && o_stall) pushback++;
            if (o_valid && !i_stall) begin
                averages_out++;
                if (averages_due.size() == 0)
                    report_mismatch("average with no sample pending", o_average, '0);
                else if (o_average !== averages_due[0])
                    report_mismatch("average", o_average, averages_due.pop_front());
                else
                    void'(averages_due.pop_front());
            end
        end
    end

    // watchdog: no beat in either direction for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            stuck = 0;
        else
            stuck++;
        if (stuck >= STUCK_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d averages pending",
                     STUCK_LIMIT, averages_due.size());
            $display("[moving_average_filter] ERROR");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off mid-run
    initial begin
        int run_len;
        int rate;
        int tick;
        i_stall <= 1'b0;
        rate = 0;
        tick = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            tick++;
            if (tick % 64 == 0) rate = $urandom_range(0, 3);
            if (!hold_done && samples_sent >= HOLD_AT) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_stall <= 1'b0;
                hold_done = 1;
            end else if (!quiet && rate != 0 && $urandom_range(0, (8 << rate) - 1) == 0) begin
                run_len = $urandom_range(1, 12);
                i_stall <= 1'b1;
                repeat (run_len) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // sender
    initial begin
        logic [SAMPLE_BITS-1:0] s;
        logic                   typed;
        logic [AVG_W-1:0]       avg;
        int                     style;
        int                     gap_rate;
        int                     idx;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_sample    <= '0;
        row_typed   <= 1'b0;
        row_average <= '0;
        win_sum  = '0;
        win_ptr  = '0;
        win_fill = '0;
        win_full = 1'b0;
        style    = 0;
        gap_rate = 0;

        // a window of full-scale samples: every mean is full scale, the
        // first needs a divisor of one and the sixteenth wraps the pointer
        for (idx = 0; idx < WINDOW; idx++) rows[idx] = '{12'hFFF, 1'b1, 12'hFFF};
        rows[16] = '{12'h000, 1'b0, 12'h000};   // oldest max leaves the sum
        rows[17] = '{12'h555, 1'b0, 12'h000};
        rows[18] = '{12'hAAA, 1'b0, 12'h000};
        rows[19] = '{12'h001, 1'b0, 12'h000};
        rows[20] = '{12'h800, 1'b0, 12'h000};
        rows[21] = '{12'h7FF, 1'b0, 12'h000};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (idx = 0; idx < N_ROWS + N_RANDOM; idx++) begin
            if (idx < N_ROWS) begin
                s     = rows[idx].sample;
                typed = rows[idx].typed;
                avg   = rows[idx].average;
            end else begin
                if ((idx - N_ROWS) % 64 == 0) begin
                    style    = $urandom_range(0, 3);
                    gap_rate = $urandom_range(0, 3);
                end
                typed = 1'b0;
                avg   = '0;
                case ($urandom_range(0, 15))
                    0:       s = '0;
                    1:       s = '1;
                    2:       s = SAMPLE_BITS'(1) << $urandom_range(0, SAMPLE_BITS - 1);
                    default: begin
                        case (style)
                            1:       s = SAMPLE_BITS'($urandom_range(3800, 4095));
                            2:       s = SAMPLE_BITS'($urandom_range(0, 300));
                            3:       s = $urandom_range(0, 1)
                                         ? SAMPLE_BITS'($urandom_range(4000, 4095))
                                         : SAMPLE_BITS'($urandom_range(0, 95));
                            default: s = SAMPLE_BITS'($urandom_range(0, 4095));
                        endcase
                    end
                endcase
            end

            i_valid     <= 1'b1;
            i_sample    <= s;
            row_typed   <= typed;
            row_average <= avg;
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            @(negedge i_clk);
            samples_sent++;
            quiet = (idx >= N_ROWS + N_RANDOM - QUIET_ITEMS);

            if (!quiet && gap_rate != 0 && $urandom_range(0, (1 << gap_rate) - 1) == 0) begin
                i_valid  <= 1'b0;
                i_sample <= SAMPLE_BITS'($urandom);   // payload is don't-care while idle
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
        i_valid <= 1'b0;

        while (averages_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d samples (%0d from the table), %0d averages checked",
                 samples_in, N_ROWS, averages_out);
        $display("input held off for %0d cycles, %0d mismatches", pushback, errors);
        if (errors == 0) begin
            $display("[moving_average_filter] OK");
        end else begin
            $display("[moving_average_filter] ERROR");
        end
        $finish;
    end

endmodule
